// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  localparam int unsigned SCREEN_WIDTH  = 80;
  localparam int unsigned SCREEN_HEIGHT = 25;
  localparam int unsigned CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W        = $clog2(CELL_COUNT);

  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned FUNC_W = 3;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_WIDTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 3'd0,
    FUNC_MOVE  = 3'd1,
    FUNC_CLEAR = 3'd2,
    FUNC_DRAW  = 3'd3,
    FUNC_READ  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_PUSH
  } state_e;

  function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] r);
    return (r > ROW_LAST) ? ROW_LAST : r;
  endfunction

  function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] c);
    return (c > COL_LAST) ? COL_LAST : c;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ROW_STRIDE) + ADDR_W'(c);
  endfunction

endpackage

// ===== rtl/core/text_console_writer_top.sv =====
// Each item is accepted, executed and its result loaded; a cell read is no slower.
// No new item is taken until the result is loaded; a held output delays that load.
// Scroll copies rows 1-24 up a row and blanks the last row; clear blanks every cell;
// input stalls. Reset (rst_ni low, async): cursor homed, attribute 0x0F, then a pass
// writes zero to every cell of the screen RAM before the first item is taken.
module text_console_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // text_attribute
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // char_code[7:0], row[12:8], col[19:13],
                                       // fg[23:20], bg[27:24], zero[31:28]
  input  logic [2:0]  s_axis_tuser_i,  // func[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // cell_value[15:0], cursor_row_now[20:16],
                                       // cursor_col_now[27:21], scrolled[28], zero[31:29]
);

  localparam int unsigned AW = tcw_pkg::ADDR_W;

  tcw_pkg::state_e state_q, state_d;

  logic [AW-1:0] idx_q, idx_d;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;

  logic [tcw_pkg::FUNC_W-1:0] func_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;
  logic [3:0]                 fg_q, bg_q;

  logic [tcw_pkg::ROW_W-1:0]  cur_y_q, cur_y_d;
  logic [tcw_pkg::COL_W-1:0]  cur_x_q, cur_x_d;
  logic                       scr_q, scr_d;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;

  logic                       out_valid_q;
  logic [31:0]                out_data_q;
  logic                       out_load;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic                       in_take;
  logic [tcw_pkg::CELL_W-1:0] blank;
  logic [AW-1:0]              pos_addr, cur_addr, bs_addr;
  logic [tcw_pkg::CELL_W-1:0] res_cell;

  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign blank    = {attr_q, tcw_pkg::CH_SPACE};
  assign pos_addr = tcw_pkg::cell_addr(tcw_pkg::sat_row(row_q), tcw_pkg::sat_col(col_q));
  assign cur_addr = tcw_pkg::cell_addr(cur_y_q, cur_x_q);
  assign bs_addr  = tcw_pkg::cell_addr(cur_y_q, cur_x_q - tcw_pkg::COL_W'(1));
  assign res_cell = (func_q == tcw_pkg::FUNC_READ) ? ram_rdata : '0;

  assign s_axis_tready_o = (state_q == tcw_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  tcw_ram #(
    .DEPTH(tcw_pkg::CELL_COUNT),
    .WIDTH(tcw_pkg::CELL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cur_y_d   = cur_y_q;
    cur_x_d   = cur_x_q;
    scr_d     = scr_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;

    if (wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = ram_rdata;
    end

    case (state_q)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '0;
        idx_d     = idx_q + AW'(1);
        if (idx_q == tcw_pkg::ADDR_LAST) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_take) begin
          state_d = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        scr_d   = 1'b0;
        state_d = tcw_pkg::ST_PUSH;
        case (func_q)
          tcw_pkg::FUNC_PUT: begin
            if (char_q == tcw_pkg::CH_BACKSPACE) begin
              if (cur_x_q != '0) begin
                cur_x_d   = cur_x_q - tcw_pkg::COL_W'(1);
                ram_we    = 1'b1;
                ram_waddr = bs_addr;
                ram_wdata = blank;
              end
            end else begin
              if (char_q != tcw_pkg::CH_NEWLINE) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr_q, char_q};
                cur_x_d   = cur_x_q + tcw_pkg::COL_W'(1);
              end
              if (char_q == tcw_pkg::CH_NEWLINE || cur_x_q == tcw_pkg::COL_LAST) begin
                cur_x_d = '0;
                if (cur_y_q == tcw_pkg::ROW_LAST) begin
                  scr_d   = 1'b1;
                  idx_d   = '0;
                  state_d = tcw_pkg::ST_SCROLL;
                end else begin
                  cur_y_d = cur_y_q + tcw_pkg::ROW_W'(1);
                end
              end
            end
          end
          tcw_pkg::FUNC_MOVE: begin
            cur_y_d = tcw_pkg::sat_row(row_q);
            cur_x_d = tcw_pkg::sat_col(col_q);
          end
          tcw_pkg::FUNC_CLEAR: begin
            cur_y_d = '0;
            cur_x_d = '0;
            idx_d   = '0;
            state_d = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::FUNC_DRAW: begin
            ram_we    = 1'b1;
            ram_waddr = pos_addr;
            ram_wdata = {bg_q, fg_q, char_q};
          end
          tcw_pkg::FUNC_READ: begin
            ram_re    = 1'b1;
            ram_raddr = pos_addr;
          end
          default: begin
          end
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q + tcw_pkg::ROW_STRIDE;
        if (idx_q == tcw_pkg::SCROLL_LAST) begin
          idx_d   = tcw_pkg::BOTTOM_ROW;
          state_d = tcw_pkg::ST_FILL;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      tcw_pkg::ST_FILL: begin
        if (!wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = blank;
          idx_d     = idx_q + AW'(1);
          if (idx_q == tcw_pkg::ADDR_LAST) begin
            state_d = tcw_pkg::ST_PUSH;
          end
        end
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = blank;
        idx_d     = idx_q + AW'(1);
        if (idx_q == tcw_pkg::ADDR_LAST) begin
          state_d = tcw_pkg::ST_PUSH;
        end
      end
      tcw_pkg::ST_PUSH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_INIT;
      idx_q       <= '0;
      wr_pend_q   <= 1'b0;
      cur_y_q     <= '0;
      cur_x_q     <= '0;
      scr_q       <= 1'b0;
      attr_q      <= tcw_pkg::ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      wr_pend_q <= (state_q == tcw_pkg::ST_SCROLL);
      cur_y_q   <= cur_y_d;
      cur_x_q   <= cur_x_d;
      scr_q     <= scr_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= idx_q;
    if (in_take) begin
      func_q <= s_axis_tuser_i;
      char_q <= s_axis_tdata_i[7:0];
      row_q  <= s_axis_tdata_i[12:8];
      col_q  <= s_axis_tdata_i[19:13];
      fg_q   <= s_axis_tdata_i[23:20];
      bg_q   <= s_axis_tdata_i[27:24];
    end
    if (out_load) begin
      out_data_q <= {3'b000, scr_q, cur_x_q, cur_y_q, res_cell};
    end
  end

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_x_q <= tcw_pkg::COL_LAST) && (cur_y_q <= tcw_pkg::ROW_LAST))
    else $error("cursor left the screen");

  a_scroll_on_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[28] |-> m_axis_tdata_o[20:16] == tcw_pkg::ROW_LAST)
    else $error("scroll reported with cursor off the bottom row");

  a_pend_after_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(state_q == tcw_pkg::ST_SCROLL))
    else $error("copy write without a scroll read");

  a_no_take_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_SCROLL || state_q == tcw_pkg::ST_CLEAR
      || state_q == tcw_pkg::ST_INIT |-> !s_axis_tready_o)
    else $error("input ready during a buffer sweep");

  a_exec_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == tcw_pkg::ST_EXEC)
    else $error("accepted item not executed");
`endif

endmodule

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
